[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted
`define RHC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Clocked check that also holds through reset
`define RHC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

[rtl/core/rhc_pkg.sv]
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int DIV_BITS    = 8;
    localparam int NUM_W       = 17;
    localparam int DEN_W       = 9;
    localparam int CORE_LAT    = DIV_BITS + 2;
    localparam int PIPE_LAT    = CORE_LAT + 1;
    localparam int H2R_STAGES  = 5;
    localparam int RECIP_SHIFT = 21;
    localparam int LUM_SHIFT   = 17;

    localparam logic [7:0]  HLS_MAX  = 8'd240;
    localparam logic [14:0] RECIP_75 = 15'd27963;
    // 240/510 is 8/17; 8 * ceil(2^17 / 17) is exact for sums up to 510
    localparam logic [15:0] LUM_RECIP = 16'd61688;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic [7:0] sat;
        logic [7:0] lum;
        logic [7:0] hue;
    } hls_t;

    // Weight of q-p along the hue ramp for a position t on 0..240
    function automatic logic [5:0] ramp_weight(input logic [7:0] t);
        logic [7:0] w;
        w = 8'd0;
        if (t < 8'd40) begin
            w = t;
        end else if (t < 8'd120) begin
            w = 8'd40;
        end else if (t < 8'd160) begin
            w = 8'd160 - t;
        end
        return w[5:0];
    endfunction

endpackage

[rtl/core/rgb_hls_color_convert.sv]
`timescale 1ns / 1ps

// RGB <-> HLS (0..240 scale) color converter on a stream. tuser[0] selects
// the direction: 0 turns red/green/blue into hue/luminance/saturation, 1
// turns hue/luminance/saturation into red/green/blue; the fields of the
// unused direction read as zero. One pixel is taken every clock, and each
// result passes two setup stages, an eight-stage bit-per-stage restoring
// divider for the RGB to HLS quotients (the HLS to RGB side is padded to
// match), and the output register. The whole pipeline holds while a result
// waits at the output.
module rgb_hls_color_convert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red[7:0], green[15:8], blue[23:16], hue[31:24], lum[39:32], sat[47:40]
    input  logic [47:0] s_tdata,
    // mode[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hue[7:0], lum[15:8], sat[23:16], red[31:24], green[39:32], blue[47:40]
    output logic [47:0] m_tdata
);

    logic en;
    logic [rhc_pkg::PIPE_LAT-1:0] vld_reg;
    logic [rhc_pkg::CORE_LAT-1:0] mode_reg;
    rhc_pkg::rgb_t rgb_in, rgb_res, rgb_out_reg;
    rhc_pkg::hls_t hls_in, hls_res, hls_out_reg;

    // Advance whenever the output slot is free or being taken
    assign en       = !vld_reg[rhc_pkg::PIPE_LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[rhc_pkg::PIPE_LAT-1];

    assign rgb_in = '{blue: s_tdata[23:16], green: s_tdata[15:8], red: s_tdata[7:0]};
    assign hls_in = '{sat: s_tdata[47:40], lum: s_tdata[39:32], hue: s_tdata[31:24]};

    rhc_rgb2hls u_rgb2hls (
        .aclk(aclk), .en(en), .rgb_in(rgb_in), .hls_out(hls_res)
    );

    rhc_hls2rgb u_hls2rgb (
        .aclk(aclk), .en(en), .hls_in(hls_in), .rgb_out(rgb_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[rhc_pkg::PIPE_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg <= {mode_reg[rhc_pkg::CORE_LAT-2:0], s_tuser[0]};
            if (mode_reg[rhc_pkg::CORE_LAT-1]) begin
                hls_out_reg <= '0;
                rgb_out_reg <= rgb_res;
            end else begin
                hls_out_reg <= hls_res;
                rgb_out_reg <= '0;
            end
        end
    end

    assign m_tdata = {rgb_out_reg, hls_out_reg};

endmodule

[rtl/core/rhc_div.sv]
`timescale 1ns / 1ps

module rhc_div (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [rhc_pkg::NUM_W-1:0]  num_in,
    input  logic [rhc_pkg::DEN_W-1:0]  den_in,
    output logic [rhc_pkg::DIV_BITS-1:0] quo_out
);

    logic [rhc_pkg::NUM_W-1:0]    rem_reg [rhc_pkg::DIV_BITS];
    logic [rhc_pkg::DEN_W-1:0]    den_reg [rhc_pkg::DIV_BITS];
    logic [rhc_pkg::DIV_BITS-1:0] quo_reg [rhc_pkg::DIV_BITS];

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < rhc_pkg::DIV_BITS; k++) begin : g_stage
        localparam int SH = rhc_pkg::DIV_BITS - 1 - k;
        logic [rhc_pkg::NUM_W-1:0]    rem_in;
        logic [rhc_pkg::DEN_W-1:0]    den_in_k;
        logic [rhc_pkg::DIV_BITS-1:0] quo_in;
        logic [rhc_pkg::NUM_W-1:0]    den_sh;
        logic [rhc_pkg::NUM_W-1:0]    rem_next;
        logic [rhc_pkg::DIV_BITS-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in   = num_in;
            assign den_in_k = den_in;
            assign quo_in   = '0;
        end else begin : g_rest
            assign rem_in   = rem_reg[k-1];
            assign den_in_k = den_reg[k-1];
            assign quo_in   = quo_reg[k-1];
        end

        always_comb begin
            den_sh   = rhc_pkg::NUM_W'(den_in_k) << SH;
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= den_sh) begin
                rem_next     = rem_in - den_sh;
                quo_next[SH] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in_k;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo_out = quo_reg[rhc_pkg::DIV_BITS-1];

endmodule

[rtl/core/rhc_rgb2hls.sv]
`timescale 1ns / 1ps

module rhc_rgb2hls (
    input  logic          aclk,
    input  logic          en,
    input  rhc_pkg::rgb_t rgb_in,
    output rhc_pkg::hls_t hls_out
);

    typedef struct packed {
        logic [7:0] lum;
        logic [7:0] base;
        logic       neg;
        logic       grey;
    } side_t;

    logic [7:0] r_a_reg, g_a_reg, b_a_reg, mx_a_reg, mn_a_reg;
    logic [7:0] mx_next, mn_next;

    always_comb begin
        mx_next = (rgb_in.red > rgb_in.green) ? rgb_in.red : rgb_in.green;
        mn_next = (rgb_in.red < rgb_in.green) ? rgb_in.red : rgb_in.green;
        if (rgb_in.blue > mx_next) mx_next = rgb_in.blue;
        if (rgb_in.blue < mn_next) mn_next = rgb_in.blue;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_a_reg  <= rgb_in.red;
            g_a_reg  <= rgb_in.green;
            b_a_reg  <= rgb_in.blue;
            mx_a_reg <= mx_next;
            mn_a_reg <= mn_next;
        end
    end

    logic [rhc_pkg::NUM_W-1:0] sat_num_next, hue_num_next;
    logic [rhc_pkg::DEN_W-1:0] sat_den_next, hue_den_next;
    logic [rhc_pkg::DEN_W-1:0] sum;
    logic [24:0]               lum_prod;
    logic [7:0]                delta, pos, neg_term, mag;
    side_t                     side_next;

    always_comb begin
        sum   = {1'b0, mx_a_reg} + {1'b0, mn_a_reg};
        delta = mx_a_reg - mn_a_reg;
        sat_den_next = (sum > 9'd255) ? 9'd510 - sum : sum;
        hue_den_next = {1'b0, delta};
        // Luminance by reciprocal multiplication, no divider needed
        lum_prod = 25'(sum) * 25'(rhc_pkg::LUM_RECIP);
        side_next.lum = lum_prod[rhc_pkg::LUM_SHIFT+7:rhc_pkg::LUM_SHIFT];
        sat_num_next = rhc_pkg::NUM_W'(delta) * rhc_pkg::NUM_W'(240);
        priority if (mx_a_reg == r_a_reg) begin
            pos      = g_a_reg;
            neg_term = b_a_reg;
            side_next.base = (g_a_reg < b_a_reg) ? 8'd240 : 8'd0;
        end else if (mx_a_reg == g_a_reg) begin
            pos      = b_a_reg;
            neg_term = r_a_reg;
            side_next.base = 8'd80;
        end else begin
            pos      = r_a_reg;
            neg_term = g_a_reg;
            side_next.base = 8'd160;
        end
        side_next.neg  = pos < neg_term;
        side_next.grey = mx_a_reg == mn_a_reg;
        mag = side_next.neg ? neg_term - pos : pos - neg_term;
        hue_num_next = rhc_pkg::NUM_W'(mag) * rhc_pkg::NUM_W'(40);
    end

    logic [rhc_pkg::NUM_W-1:0] sat_num_reg, hue_num_reg;
    logic [rhc_pkg::DEN_W-1:0] sat_den_reg, hue_den_reg;
    side_t                     side_reg [rhc_pkg::DIV_BITS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_num_reg <= sat_num_next;
            hue_num_reg <= hue_num_next;
            sat_den_reg <= sat_den_next;
            hue_den_reg <= hue_den_next;
            side_reg[0] <= side_next;
            for (int k = 1; k <= rhc_pkg::DIV_BITS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    logic [7:0] sat_q, hue_q;

    rhc_div u_div_sat (
        .aclk(aclk), .en(en), .num_in(sat_num_reg),
        .den_in(sat_den_reg), .quo_out(sat_q)
    );

    rhc_div u_div_hue (
        .aclk(aclk), .en(en), .num_in(hue_num_reg),
        .den_in(hue_den_reg), .quo_out(hue_q)
    );

    side_t side_out;

    always_comb begin
        side_out    = side_reg[rhc_pkg::DIV_BITS];
        hls_out.lum = side_out.lum;
        // Grey input divides by zero; drop both quotients
        hls_out.sat = side_out.grey ? 8'd0 : sat_q;
        hls_out.hue = side_out.grey ? 8'd0 :
                      side_out.neg  ? side_out.base - hue_q : side_out.base + hue_q;
    end

endmodule

[rtl/core/rhc_hls2rgb.sv]
`timescale 1ns / 1ps

module rhc_hls2rgb (
    input  logic          aclk,
    input  logic          en,
    input  rhc_pkg::hls_t hls_in,
    output rhc_pkg::rgb_t rgb_out
);

    localparam int PAD = rhc_pkg::CORE_LAT - rhc_pkg::H2R_STAGES;

    // Stage A: wrap hue, clamp luminance and saturation
    logic [7:0] h_a_reg, l_a_reg, s_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            h_a_reg <= (hls_in.hue > rhc_pkg::HLS_MAX) ? hls_in.hue - rhc_pkg::HLS_MAX
                                                       : hls_in.hue;
            l_a_reg <= (hls_in.lum > rhc_pkg::HLS_MAX) ? rhc_pkg::HLS_MAX : hls_in.lum;
            s_a_reg <= (hls_in.sat > rhc_pkg::HLS_MAX) ? rhc_pkg::HLS_MAX : hls_in.sat;
        end
    end

    // Stage B: p and q - p over 57600, ramp weights per channel
    logic [16:0] ls, q_full, p_full, d_full;
    logic [8:0]  t_red;
    logic [7:0]  t_ch [3];
    logic [15:0] p_b_reg, d_b_reg;
    logic [5:0]  f_b_reg [3];

    always_comb begin
        ls = 17'(l_a_reg) * 17'(s_a_reg);
        if (l_a_reg < 8'd120) begin
            q_full = 17'(l_a_reg) * (17'd240 + 17'(s_a_reg));
        end else begin
            q_full = (17'(l_a_reg) + 17'(s_a_reg)) * 17'd240 - ls;
        end
        p_full = 17'(l_a_reg) * 17'd480 - q_full;
        d_full = q_full - p_full;
        t_red  = {1'b0, h_a_reg} + 9'd80;
        t_ch[0] = (t_red > 9'd240) ? 8'(t_red - 9'd240) : t_red[7:0];
        t_ch[1] = h_a_reg;
        t_ch[2] = (h_a_reg < 8'd80) ? h_a_reg + 8'd160 : h_a_reg - 8'd80;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_b_reg <= p_full[15:0];
            d_b_reg <= d_full[15:0];
            for (int c = 0; c < 3; c++) begin
                f_b_reg[c] <= rhc_pkg::ramp_weight(t_ch[c]);
            end
        end
    end

    // Stages C, D, E: value, times 17 over 2048, then over 75 by reciprocal
    logic [21:0] v_c_reg [3];
    logic [14:0] y_d_reg [3];
    logic [7:0]  o_e_reg [3];
    logic [22:0] v_next  [3];
    logic [25:0] x_next  [3];
    logic [29:0] z_next  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            v_next[c] = 23'(p_b_reg) * 23'd40 + 23'(d_b_reg) * 23'(f_b_reg[c]);
            x_next[c] = 26'(v_c_reg[c]) * 26'd17;
            z_next[c] = 30'(y_d_reg[c]) * 30'(rhc_pkg::RECIP_75);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                v_c_reg[c] <= v_next[c][21:0];
                y_d_reg[c] <= x_next[c][25:11];
                o_e_reg[c] <= z_next[c][rhc_pkg::RECIP_SHIFT+7:rhc_pkg::RECIP_SHIFT];
            end
        end
    end

    // Align with the divider path
    rhc_pkg::rgb_t pad_reg [PAD];

    always_ff @(posedge aclk) begin
        if (en) begin
            pad_reg[0] <= '{blue: o_e_reg[2], green: o_e_reg[1], red: o_e_reg[0]};
            for (int k = 1; k < PAD; k++) begin
                pad_reg[k] <= pad_reg[k-1];
            end
        end
    end

    assign rgb_out = pad_reg[PAD-1];

endmodule

[rtl/core/rhc_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rhc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic unused_in;
    assign unused_in = s_tvalid ^ (^s_tdata) ^ s_tuser[0];

    `RHC_ASSERT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `RHC_ASSERT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))
    `RHC_ASSERT(a_ready_slot, aclk, aresetn, s_tready == (!m_tvalid || m_tready))
    `RHC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `RHC_ASSERT(a_one_side, aclk, aresetn, m_tvalid |-> (m_tdata[23:0] == 24'd0 || m_tdata[47:24] == 24'd0))

endmodule

bind rgb_hls_color_convert rhc_checker u_rhc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[tb/tb_rgb_hls_color_convert.sv]
`timescale 1ns / 1ps

module tb_rgb_hls_color_convert;

    typedef struct {
        logic [47:0] data;
        logic [0:0]  mode;
    } pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    pixel_t      pending_pixels[$];
    logic [47:0] expected_colors[$];
    int          error_count;
    int          cycle_count;
    bit          stim_done;
    bit          drain_hold;
    bit          calm_phase;
    bit          in_fire;

    localparam int CYCLE_LIMIT = 400000;

    rgb_hls_color_convert uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic longint ramp_value(longint p, longint q, int t);
        if (t < 0) t += 240;
        if (t > 240) t -= 240;
        if (t < 40) return 40 * p + (q - p) * t;
        if (t < 120) return 40 * q;
        if (t < 160) return 40 * p + (q - p) * (160 - t);
        return 40 * p;
    endfunction

    function automatic logic [7:0] ramp_to_byte(longint v);
        longint r;
        if (v < 0) v = 0;
        r = (v * 255) / 2304000;
        if (r > 255) r = 255;
        return r[7:0];
    endfunction

    function automatic logic [47:0] convert_color(pixel_t px);
        int r, g, b, mx, mn, hue, lum, sat, delta, sum, h, l, s;
        longint p, q;
        logic [7:0] grey;
        logic [47:0] res;
        res = '0;
        if (px.mode == 1'b0) begin
            r = px.data[7:0];
            g = px.data[15:8];
            b = px.data[23:16];
            mx = (r > g) ? r : g;
            mn = (r < g) ? r : g;
            if (b > mx) mx = b;
            if (b < mn) mn = b;
            hue = 0;
            sat = 0;
            lum = (mx + mn) * 240 / 510;
            if (mx != mn) begin
                delta = mx - mn;
                sum = mx + mn;
                sat = (sum > 255) ? delta * 240 / (510 - sum) : delta * 240 / sum;
                if (mx == r) hue = (g - b) * 40 / delta + ((g < b) ? 240 : 0);
                else if (mx == g) hue = (b - r) * 40 / delta + 80;
                else hue = (r - g) * 40 / delta + 160;
            end
            res[7:0] = hue[7:0];
            res[15:8] = lum[7:0];
            res[23:16] = sat[7:0];
        end else begin
            h = px.data[31:24];
            l = px.data[39:32];
            s = px.data[47:40];
            if (h > 240) h -= 240;
            if (l > 240) l = 240;
            if (s > 240) s = 240;
            if (s == 0) begin
                grey = 8'((l * 255) / 240);
                res[31:24] = grey;
                res[39:32] = grey;
                res[47:40] = grey;
            end else begin
                if (l < 120) q = longint'(l) * (240 + s);
                else q = longint'(l + s) * 240 - longint'(l) * s;
                p = 480 * longint'(l) - q;
                res[31:24] = ramp_to_byte(ramp_value(p, q, h + 80));
                res[39:32] = ramp_to_byte(ramp_value(p, q, h));
                res[47:40] = ramp_to_byte(ramp_value(p, q, h - 80));
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    task automatic queue_pixel(logic m, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                               logic [7:0] d, logic [7:0] e, logic [7:0] f);
        pixel_t px;
        px.mode = m;
        px.data = {f, e, d, c, b, a};
        pending_pixels.push_back(px);
    endtask

    // Record the input transfer at the edge where it happens
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
    end

    // Driver: advance on transfer, idle at random outside the calm phase
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (in_fire) begin
                expected_colors.push_back(convert_color('{s_tdata, s_tuser}));
                void'(pending_pixels.pop_front());
            end
            if (in_fire || !s_tvalid) begin
                if (pending_pixels.size() > 0 && !drain_hold &&
                    (calm_phase || $urandom_range(99) >= 30)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pixels[0].data;
                    s_tuser  <= pending_pixels[0].mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm_phase || ($urandom_range(99) >= 30);
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected", m_tdata, 48'h0);
            end else begin
                if (m_tdata[7:0] !== expected_colors[0][7:0])
                    report_mismatch("hue", m_tdata, expected_colors[0]);
                if (m_tdata[15:8] !== expected_colors[0][15:8])
                    report_mismatch("lum", m_tdata, expected_colors[0]);
                if (m_tdata[23:16] !== expected_colors[0][23:16])
                    report_mismatch("sat", m_tdata, expected_colors[0]);
                if (m_tdata[31:24] !== expected_colors[0][31:24])
                    report_mismatch("red", m_tdata, expected_colors[0]);
                if (m_tdata[39:32] !== expected_colors[0][39:32])
                    report_mismatch("green", m_tdata, expected_colors[0]);
                if (m_tdata[47:40] !== expected_colors[0][47:40])
                    report_mismatch("blue", m_tdata, expected_colors[0]);
                void'(expected_colors.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int k;
        int kind;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        stim_done = 0;
        drain_hold = 0;
        calm_phase = 0;

        // Directed: extremes, grey, each max-channel branch, wraps and clamps
        queue_pixel(0, 0, 0, 0, 0, 0, 0);
        queue_pixel(0, 255, 255, 255, 0, 0, 0);
        queue_pixel(0, 255, 0, 0, 255, 255, 255);
        queue_pixel(0, 0, 255, 0, 0, 0, 0);
        queue_pixel(0, 0, 0, 255, 0, 0, 0);
        queue_pixel(0, 255, 0, 255, 0, 0, 0);
        queue_pixel(0, 255, 255, 0, 0, 0, 0);
        queue_pixel(0, 128, 127, 127, 0, 0, 0);
        queue_pixel(0, 1, 0, 0, 0, 0, 0);
        queue_pixel(0, 200, 10, 90, 0, 0, 0);
        queue_pixel(1, 255, 255, 255, 0, 0, 0);
        queue_pixel(1, 0, 0, 0, 0, 240, 0);
        queue_pixel(1, 0, 0, 0, 0, 120, 0);
        queue_pixel(1, 0, 0, 0, 0, 120, 240);
        queue_pixel(1, 0, 0, 0, 80, 120, 240);
        queue_pixel(1, 0, 0, 0, 160, 120, 240);
        queue_pixel(1, 0, 0, 0, 240, 119, 1);
        queue_pixel(1, 0, 0, 0, 255, 255, 255);
        queue_pixel(1, 0, 0, 0, 241, 60, 241);
        queue_pixel(1, 0, 0, 0, 40, 200, 100);
        queue_pixel(1, 0, 0, 0, 39, 30, 200);
        queue_pixel(1, 0, 0, 0, 159, 240, 240);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Random pixels, half of each mode, with a mix of in-range and raw values
        for (k = 0; k < 1300; k++) begin
            kind = $urandom_range(9);
            if (kind < 5) begin
                queue_pixel(0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (kind < 9) begin
                queue_pixel(1, $urandom, $urandom, $urandom, $urandom_range(240),
                            $urandom_range(240), $urandom_range(240));
            end else begin
                queue_pixel(1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            if (k == 400) begin
                // hold the sender until the pipeline drains
                wait (pending_pixels.size() == 0 && !s_tvalid);
                drain_hold = 1;
                wait (expected_colors.size() == 0);
                repeat (20) @(posedge aclk);
                drain_hold = 0;
            end
            if (k == 700) begin
                wait (pending_pixels.size() == 0 && !s_tvalid);
                calm_phase = 1;
            end
            if (k == 1000) begin
                wait (pending_pixels.size() == 0 && !s_tvalid);
                calm_phase = 0;
            end
        end

        wait (pending_pixels.size() == 0 && !s_tvalid);
        wait (expected_colors.size() == 0);
        repeat (40) @(posedge aclk);
        if (error_count == 0 && expected_colors.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
